// ===== hw/rtl/lcpb_pkg.sv =====
// Shared types and constants for the light command payload builder.
// Holds the port word structs, the decoded command word and the front state type.
// No dependencies.
`default_nettype none

package lcpb_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] FUNC_ON  = 2'd0;
  localparam logic [1:0] FUNC_OFF = 2'd1;
  localparam logic [1:0] FUNC_CT  = 2'd2;
  localparam logic [1:0] FUNC_HSI = 2'd3;

  localparam logic [7:0] MODE_CT  = 8'd0;
  localparam logic [7:0] MODE_HSI = 8'd1;
  localparam logic [7:0] MODE_OFF = 8'd3;
  localparam logic [7:0] MODE_ON  = 8'd4;

  localparam logic [7:0] HDR_BYTE  = 8'hEF;
  localparam logic [7:0] TAIL_B11  = 8'h11;
  localparam logic [7:0] TAIL_B12  = 8'h22;
  localparam logic [7:0] TAIL_B13  = 8'hFE;
  localparam logic [7:0] END_BYTE  = 8'h00;
  localparam logic [7:0] HSI_TAG   = 8'h99;
  localparam logic [7:0] PWR_LEVEL = 8'h64;
  localparam logic [7:0] PWR_FULL  = 8'hFF;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  localparam logic [7:0] PID_LAST = 8'd222;

  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [6:0] KV_MIN  = 7'd28;
  localparam logic [6:0] KV_MAX  = 7'd85;

  localparam logic [15:0] KELVIN_LO = 16'd2800;
  localparam logic [15:0] KELVIN_HI = 16'd8500;
  localparam logic [12:0] KV_RECIP  = 13'd5243;

  localparam logic [8:0] HUE_MAX  = 9'd360;
  localparam logic [8:0] HUE_60   = 9'd60;
  localparam logic [8:0] HUE_120  = 9'd120;
  localparam logic [8:0] HUE_180  = 9'd180;
  localparam logic [8:0] HUE_240  = 9'd240;
  localparam logic [8:0] HUE_300  = 9'd300;

  localparam logic [12:0] FULL_SCALE  = 13'd6000;
  localparam logic [5:0]  SECTOR_SPAN = 6'd60;
  localparam logic [17:0] SCALE_RECIP = 18'd214749;

  localparam logic [3:0] LAST_INDEX = 4'd15;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MULT,
    F_MIX,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  channel;
    logic [2:0]  group;
    logic [15:0] kelvin;
    logic [7:0]  brightness;
    logic [15:0] hue;
    logic [7:0]  saturation;
  } in_word_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] byte_index;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [7:0]      addr_byte;
    logic [7:0]      mode;
    logic [7:0][7:0] data;
    logic [7:0]      pid;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcpb_front.sv =====
// Front end: accepts a command word, clamps its values, converts HSI color to RGB
// and pushes the decoded command into the queue. Depends on lcpb_pkg.
`default_nettype none

module lcpb_front
  import lcpb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_word_t cmd,
  output logic     q_push,
  input  logic     q_full,
  output cmd_t     q_data
);

  front_state_t state, state_next;

  logic [1:0]  func;
  logic [7:0]  addr_byte;
  logic [6:0]  bri;
  logic [6:0]  sat;
  logic [6:0]  kv;
  logic [8:0]  hue;
  logic [7:0]  pid;
  logic [7:0]  pid_next;
  logic [13:0] vs;
  logic [19:0] full_lvl;
  logic [2:0]  sector;
  logic [5:0]  hue_off;
  logic [17:0] scaled [3];
  logic [7:0]  quo [3];

  logic        accept;
  logic [6:0]  bri_c;
  logic [6:0]  sat_c;
  logic [8:0]  hue_c;
  logic [6:0]  kv_c;
  logic [25:0] kv_prod;
  logic [2:0]  grp_c;
  logic [8:0]  hm;
  logic [2:0]  sector_c;
  logic [8:0]  r120;
  logic [5:0]  hue_off_c;
  logic [19:0] vs60;
  logic [19:0] vsd;
  logic [19:0] base_lvl;
  logic [19:0] mid_lvl;
  logic [19:0] lvl [3];
  logic [23:0] lvl_x17 [3];
  logic [34:0] scale_prod [3];

  assign accept = push && !full;

  always_comb begin
    bri_c   = (cmd.brightness > 8'(PCT_MAX)) ? PCT_MAX : cmd.brightness[6:0];
    sat_c   = (cmd.saturation > 8'(PCT_MAX)) ? PCT_MAX : cmd.saturation[6:0];
    hue_c   = (cmd.hue > 16'(HUE_MAX)) ? HUE_MAX : cmd.hue[8:0];
    kv_prod = 26'(cmd.kelvin[13:0]) * 26'(KV_RECIP);
    if (cmd.kelvin < KELVIN_LO) begin
      kv_c = KV_MIN;
    end else if (cmd.kelvin >= KELVIN_HI) begin
      kv_c = KV_MAX;
    end else begin
      kv_c = kv_prod[25:19];
    end
    grp_c    = (cmd.func == FUNC_ON || cmd.func == FUNC_OFF) ? 3'd0 : cmd.group;
    pid_next = (pid == PID_LAST) ? 8'd0 : pid + 8'd1;
  end

  always_comb begin
    hm = (hue == HUE_MAX) ? 9'd0 : hue;
    if (hm < HUE_60) begin
      sector_c = 3'd0;
    end else if (hm < HUE_120) begin
      sector_c = 3'd1;
    end else if (hm < HUE_180) begin
      sector_c = 3'd2;
    end else if (hm < HUE_240) begin
      sector_c = 3'd3;
    end else if (hm < HUE_300) begin
      sector_c = 3'd4;
    end else begin
      sector_c = 3'd5;
    end
    if (sector_c[2]) begin
      r120 = hm - HUE_240;
    end else if (sector_c[1]) begin
      r120 = hm - HUE_120;
    end else begin
      r120 = hm;
    end
    hue_off_c = (r120 >= HUE_60) ? 6'(r120 - HUE_60) : 6'(HUE_60 - r120);
  end

  always_comb begin
    vs60     = 20'(vs) * 20'(SECTOR_SPAN);
    vsd      = 20'(vs) * 20'(hue_off);
    base_lvl = full_lvl - vs60;
    mid_lvl  = full_lvl - vsd;
    case (sector)
      3'd0: begin
        lvl[0] = full_lvl; lvl[1] = mid_lvl;  lvl[2] = base_lvl;
      end
      3'd1: begin
        lvl[0] = mid_lvl;  lvl[1] = full_lvl; lvl[2] = base_lvl;
      end
      3'd2: begin
        lvl[0] = base_lvl; lvl[1] = full_lvl; lvl[2] = mid_lvl;
      end
      3'd3: begin
        lvl[0] = base_lvl; lvl[1] = mid_lvl;  lvl[2] = full_lvl;
      end
      3'd4: begin
        lvl[0] = mid_lvl;  lvl[1] = base_lvl; lvl[2] = full_lvl;
      end
      default: begin
        lvl[0] = full_lvl; lvl[1] = base_lvl; lvl[2] = mid_lvl;
      end
    endcase
    // scale by 255/600000 = 17/40000: drop 2^6, then multiply by 2^27/625
    for (int i = 0; i < 3; i++) begin
      lvl_x17[i]    = (24'(lvl[i]) << 4) + 24'(lvl[i]);
      scale_prod[i] = 35'(scaled[i]) * 35'(SCALE_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      pid   <= 8'd0;
    end else begin
      state <= state_next;
      if (accept) begin
        pid <= pid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          func      <= cmd.func;
          addr_byte <= {cmd.channel, grp_c};
          bri       <= bri_c;
          sat       <= sat_c;
          hue       <= hue_c;
          kv        <= kv_c;
        end
      end
      F_MULT: begin
        vs       <= 14'(bri) * 14'(sat);
        full_lvl <= 20'(bri) * 20'(FULL_SCALE);
        sector   <= sector_c;
        hue_off  <= hue_off_c;
      end
      F_MIX: begin
        for (int i = 0; i < 3; i++) begin
          scaled[i] <= lvl_x17[i][23:6];
        end
      end
      F_DIV: begin
        for (int i = 0; i < 3; i++) begin
          quo[i] <= scale_prod[i][34:27];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (push) begin
          state_next = (cmd.func == FUNC_HSI) ? F_MULT : F_PUSH;
        end
      end
      F_MULT: state_next = F_MIX;
      F_MIX:  state_next = F_DIV;
      F_DIV:  state_next = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full   = (state != F_IDLE);
    q_push = (state == F_PUSH);
    q_data.addr_byte = addr_byte;
    q_data.pid       = pid;
    q_data.data      = '0;
    case (func)
      FUNC_ON, FUNC_OFF: begin
        q_data.mode    = (func == FUNC_ON) ? MODE_ON : MODE_OFF;
        q_data.data[0] = ZERO_BYTE;
        q_data.data[1] = PWR_LEVEL;
        q_data.data[2] = PWR_FULL;
        q_data.data[3] = PWR_FULL;
        q_data.data[4] = PWR_FULL;
      end
      FUNC_CT: begin
        q_data.mode    = MODE_CT;
        q_data.data[0] = {1'b0, kv};
        q_data.data[1] = {1'b0, bri};
      end
      FUNC_HSI: begin
        q_data.mode    = MODE_HSI;
        q_data.data[0] = HSI_TAG;
        q_data.data[1] = {1'b0, bri};
        q_data.data[2] = quo[0];
        q_data.data[3] = quo[1];
        q_data.data[4] = quo[2];
        q_data.data[5] = {7'd0, hue[8]};
        q_data.data[6] = hue[7:0];
        q_data.data[7] = {1'b0, sat};
      end
      default: begin
        q_data.mode = MODE_CT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lcpb_queue.sv =====
// Short command queue between the front end and the byte sequencer.
// Register array with read and write pointers. Depends on lcpb_pkg.
`default_nettype none

module lcpb_queue
  import lcpb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  cmd_t data_in,
  input  logic pop,
  output logic empty,
  output cmd_t data_out
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          wr;
  logic          rd;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign wr       = push && !full;
  assign rd       = pop && !empty;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lcpb_back.sv =====
// Back end: takes decoded commands from the queue and emits the 16 payload bytes
// through an output register, one word per cycle while the result side keeps popping. Depends on lcpb_pkg.
`default_nettype none

module lcpb_back
  import lcpb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  cmd_t      q_data,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_word_t result
);

  cmd_t      cur;
  logic      cur_valid;
  logic [3:0] idx;
  logic      out_valid;
  out_word_t out_word;

  logic       load;
  logic       fetch;
  logic [7:0] sel_byte;

  assign load   = cur_valid && (!out_valid || pop);
  assign fetch  = !cur_valid || (load && idx == LAST_INDEX);
  assign q_pop  = fetch && !q_empty;
  assign empty  = !out_valid;
  assign result = out_word;

  always_comb begin
    case (idx)
      4'd0:    sel_byte = HDR_BYTE;
      4'd1:    sel_byte = cur.addr_byte;
      4'd2:    sel_byte = cur.mode;
      4'd3:    sel_byte = cur.data[0];
      4'd4:    sel_byte = cur.data[1];
      4'd5:    sel_byte = cur.data[2];
      4'd6:    sel_byte = cur.data[3];
      4'd7:    sel_byte = cur.data[4];
      4'd8:    sel_byte = cur.data[5];
      4'd9:    sel_byte = cur.data[6];
      4'd10:   sel_byte = cur.data[7];
      4'd11:   sel_byte = TAIL_B11;
      4'd12:   sel_byte = TAIL_B12;
      4'd13:   sel_byte = TAIL_B13;
      4'd14:   sel_byte = cur.pid;
      4'd15:   sel_byte = END_BYTE;
      default: sel_byte = END_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= 4'd0;
      end else if (load && idx == LAST_INDEX) begin
        cur_valid <= 1'b0;
      end else if (load) begin
        idx <= idx + 4'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (load) begin
      out_word.payload_byte <= sel_byte;
      out_word.byte_index   <= idx;
      out_word.last         <= (idx == LAST_INDEX);
    end
  end

`ifndef SYNTH
  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.last == (out_word.byte_index == LAST_INDEX)))
    else $error("last flag does not match final byte index");

  a_header_first: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.byte_index == 4'd0) |-> (out_word.payload_byte == HDR_BYTE))
    else $error("payload does not open with header byte");

  a_index_advances: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pop && !out_word.last) |=>
      (out_valid && out_word.byte_index == $past(out_word.byte_index) + 4'd1))
    else $error("byte index did not advance within a payload");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/light_command_payload_builder_core.sv =====
// Light command payload builder top level: front end, command queue, byte sequencer.
// Depends on lcpb_pkg, lcpb_front, lcpb_queue and lcpb_back.
//
// Usage:
//   Command channel: drive cmd and raise push; the word is taken on a rising edge
//   with push high and full low. full then stays high while the front end works on
//   the command: the queue write for power and color temperature commands, and for
//   hue/saturation/intensity multiply, mix, reciprocal scaling of the three RGB
//   lanes and the queue write, so no new command is taken while one is in work.
//   full also holds while the queue has no free entry.
//   Result channel: while empty is low, result holds the oldest payload byte; it
//   is taken on a rising edge with pop high. Each command yields 16 words, byte 0
//   first, last set on byte 15. The output register reloads in the cycle it is
//   popped, so the sequencer gives one word per cycle while pop stays high; that
//   sequencer sets the sustained rate. After acceptance the first word passes the
//   front end state machine, a queue entry, the command and output registers.
//   A stalled result side fills the queue and then holds full high; nothing drops.
//   Reset (rst, synchronous) empties the queue and output register and clears the
//   rolling packet id to zero.
`default_nettype none

module light_command_payload_builder_core
  import lcpb_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_word_t  cmd,
  output logic      empty,
  input  logic      pop,
  output out_word_t result
);

  logic q_push;
  logic q_full;
  cmd_t q_wdata;
  logic q_pop;
  logic q_empty;
  cmd_t q_rdata;

  lcpb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .cmd    (cmd),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_wdata)
  );

  lcpb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .full     (q_full),
    .data_in  (q_wdata),
    .pop      (q_pop),
    .empty    (q_empty),
    .data_out (q_rdata)
  );

  lcpb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

// ===== verif/light_command_payload_builder_core_tb.sv =====
// Testbench for light_command_payload_builder_core: drives lighting commands and checks
// every payload word against an in-bench payload builder with its own packet id.
// Depends on lcpb_pkg and the core RTL.
`default_nettype none

module light_command_payload_builder_core_tb;
  import lcpb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_word_t  cmd = '0;
  logic      full;
  logic      empty;
  out_word_t result;

  in_word_t  pending_cmds[$];
  out_word_t expected_bytes[$];
  logic [7:0] model_pid = 8'd0;
  logic      cmd_taken = 1'b0;
  int        cmds_queued = 0;
  int        cmds_taken = 0;
  int        cycle_count = 0;
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  light_command_payload_builder_core dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .cmd    (cmd),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Build the 16 payload words of one command and advance the packet id.
  function automatic void build_payload(input in_word_t c);
    logic [7:0] frame [0:15];
    logic [7:0] bri;
    logic [7:0] sat;
    logic [15:0] hue_c;
    logic [2:0] grp;
    int unsigned kv, hm, sector, r120, tri_off, vs, full_v, base_v, mid_v;
    int unsigned lane [0:2];
    out_word_t w;
    begin
      for (int i = 0; i < 16; i++) frame[i] = ZERO_BYTE;
      bri = (c.brightness > PCT_MAX) ? 8'(PCT_MAX) : c.brightness;
      grp = c.group;
      case (c.func)
        FUNC_ON, FUNC_OFF: begin
          grp = 3'd0;
          frame[2] = (c.func == FUNC_ON) ? MODE_ON : MODE_OFF;
          frame[4] = PWR_LEVEL;
          frame[5] = PWR_FULL;
          frame[6] = PWR_FULL;
          frame[7] = PWR_FULL;
        end
        FUNC_CT: begin
          kv = c.kelvin / 100;
          if (kv < KV_MIN) kv = KV_MIN;
          if (kv > KV_MAX) kv = KV_MAX;
          frame[2] = MODE_CT;
          frame[3] = 8'(kv);
          frame[4] = bri;
        end
        default: begin
          hue_c = (c.hue > HUE_MAX) ? 16'(HUE_MAX) : c.hue;
          sat = (c.saturation > PCT_MAX) ? 8'(PCT_MAX) : c.saturation;
          hm = hue_c % 360;
          sector = hm / 60;
          r120 = hm % 120;
          tri_off = (r120 >= 60) ? r120 - 60 : 60 - r120;
          vs = bri * sat;
          full_v = bri * 6000;
          base_v = full_v - vs * 60;
          mid_v = base_v + vs * (60 - tri_off);
          case (sector)
            0: begin lane[0] = full_v; lane[1] = mid_v;  lane[2] = base_v; end
            1: begin lane[0] = mid_v;  lane[1] = full_v; lane[2] = base_v; end
            2: begin lane[0] = base_v; lane[1] = full_v; lane[2] = mid_v;  end
            3: begin lane[0] = base_v; lane[1] = mid_v;  lane[2] = full_v; end
            4: begin lane[0] = mid_v;  lane[1] = base_v; lane[2] = full_v; end
            default: begin lane[0] = full_v; lane[1] = base_v; lane[2] = mid_v; end
          endcase
          frame[2] = MODE_HSI;
          frame[3] = HSI_TAG;
          frame[4] = bri;
          for (int k = 0; k < 3; k++) frame[5 + k] = 8'((lane[k] * 255) / 600000);
          frame[8] = hue_c[15:8];
          frame[9] = hue_c[7:0];
          frame[10] = sat;
        end
      endcase
      model_pid = (model_pid == PID_LAST) ? 8'd0 : model_pid + 8'd1;
      frame[0] = HDR_BYTE;
      frame[1] = {c.channel, grp};
      frame[11] = TAIL_B11;
      frame[12] = TAIL_B12;
      frame[13] = TAIL_B13;
      frame[14] = model_pid;
      frame[15] = END_BYTE;
      for (int i = 0; i < 16; i++) begin
        w.payload_byte = frame[i];
        w.byte_index = 4'(i);
        w.last = (4'(i) == LAST_INDEX);
        expected_bytes.push_back(w);
      end
    end
  endfunction

  task automatic check_word(input out_word_t got);
    out_word_t want;
    begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
      end else begin
        want = expected_bytes.pop_front();
        if (got.payload_byte !== want.payload_byte)
          report_mismatch($sformatf("byte %0d payload_byte got %h want %h",
                                    want.byte_index, got.payload_byte, want.payload_byte));
        if (got.byte_index !== want.byte_index)
          report_mismatch($sformatf("byte_index got %0d want %0d",
                                    got.byte_index, want.byte_index));
        if (got.last !== want.last)
          report_mismatch($sformatf("byte %0d last got %b want %b",
                                    want.byte_index, got.last, want.last));
      end
    end
  endtask

  task automatic queue_cmd(input logic [1:0] f, input logic [4:0] ch, input logic [2:0] grp,
                           input logic [15:0] kel, input logic [7:0] bri,
                           input logic [15:0] hue, input logic [7:0] sat);
    in_word_t c;
    begin
      c.func = f;
      c.channel = ch;
      c.group = grp;
      c.kelvin = kel;
      c.brightness = bri;
      c.hue = hue;
      c.saturation = sat;
      pending_cmds.push_back(c);
      cmds_queued++;
    end
  endtask

  function automatic in_word_t random_cmd();
    in_word_t c;
    begin
      c.func = 2'($urandom_range(3));
      c.channel = 5'($urandom);
      c.group = 3'($urandom);
      c.kelvin = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(9000, 2000));
      c.brightness = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(110));
      case ($urandom_range(2))
        0: c.hue = 16'($urandom_range(360));
        1: c.hue = 16'($urandom_range(370, 350));
        default: c.hue = 16'($urandom);
      endcase
      c.saturation = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(110));
      return c;
    end
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      pending_cmds.push_back(random_cmd());
      cmds_queued++;
    end
  endtask

  task automatic wait_all_taken();
    while (cmds_taken != cmds_queued) @(posedge clk);
  endtask

  // Sample handshakes, check results, predict on every accepted command.
  always @(posedge clk) begin
    cycle_count++;
    cmd_taken = !rst && push && !full;
    if (!rst && pop && !empty) check_word(result);
    if (cmd_taken) begin
      build_payload(cmd);
      cmds_taken++;
    end
  end

  // Drive at the falling edge; hold a command until it is taken.
  always @(negedge clk) begin
    if (!rst && (!push || cmd_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd <= pending_cmds.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
    pop <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[light_command_payload_builder_core] ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 17;
    recv_idle_pct = 58;
    queue_cmd(FUNC_ON,  5'd31, 3'd7, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
    queue_cmd(FUNC_OFF, 5'd0,  3'd7, 16'd0,    8'd0,  16'd0,    8'd0);
    queue_cmd(FUNC_ON,  5'd16, 3'd3, 16'd2800, 8'd50, 16'd180,  8'd50);
    queue_cmd(FUNC_CT,  5'd1,  3'd1, 16'd0,    8'd0,  16'd0,    8'd0);
    queue_cmd(FUNC_CT,  5'd2,  3'd2, 16'd2799, 8'd100, 16'd5,   8'd5);
    queue_cmd(FUNC_CT,  5'd3,  3'd4, 16'd2800, 8'd101, 16'd5,   8'd5);
    queue_cmd(FUNC_CT,  5'd4,  3'd5, 16'd8599, 8'd255, 16'd5,   8'd5);
    queue_cmd(FUNC_CT,  5'd5,  3'd6, 16'd8600, 8'd99,  16'd5,   8'd5);
    queue_cmd(FUNC_CT,  5'd31, 3'd7, 16'hFFFF, 8'd1,   16'd5,   8'd5);
    queue_cmd(FUNC_HSI, 5'd6,  3'd0, 16'd0, 8'd100, 16'd0,   8'd100);
    queue_cmd(FUNC_HSI, 5'd7,  3'd1, 16'd0, 8'd100, 16'd60,  8'd100);
    queue_cmd(FUNC_HSI, 5'd8,  3'd2, 16'd0, 8'd100, 16'd120, 8'd100);
    queue_cmd(FUNC_HSI, 5'd9,  3'd3, 16'd0, 8'd100, 16'd180, 8'd100);
    queue_cmd(FUNC_HSI, 5'd10, 3'd4, 16'd0, 8'd100, 16'd240, 8'd100);
    queue_cmd(FUNC_HSI, 5'd11, 3'd5, 16'd0, 8'd100, 16'd300, 8'd100);
    queue_cmd(FUNC_HSI, 5'd12, 3'd6, 16'd0, 8'd100, 16'd359, 8'd100);
    queue_cmd(FUNC_HSI, 5'd13, 3'd7, 16'd0, 8'd77,  16'd360, 8'd64);
    queue_cmd(FUNC_HSI, 5'd14, 3'd0, 16'd0, 8'd77,  16'd361, 8'd64);
    queue_cmd(FUNC_HSI, 5'd31, 3'd7, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
    queue_cmd(FUNC_HSI, 5'd0,  3'd0, 16'd0, 8'd0,   16'd200, 8'd0);
    queue_cmd(FUNC_HSI, 5'd15, 3'd1, 16'd0, 8'd50,  16'd90,  8'd50);
    queue_cmd(FUNC_HSI, 5'd17, 3'd2, 16'd0, 8'd73,  16'd30,  8'd101);
    queue_cmd(FUNC_HSI, 5'd18, 3'd3, 16'd0, 8'd101, 16'd330, 8'd1);
    wait_all_taken();
    while (expected_bytes.size() != 0) @(posedge clk);

    queue_random(120);
    wait_all_taken();

    send_idle_pct = 58;
    recv_idle_pct = 17;
    queue_random(115);
    wait_all_taken();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(115);
    wait_all_taken();

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_bytes.size()));

    if (mismatch_count == 0)
      $display("[light_command_payload_builder_core] OK");
    else
      $display("[light_command_payload_builder_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
